FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DGSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DGSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/dgsp_pkg.sv
package dgsp_pkg;

  localparam int EDGE_W = 16;
  localparam int DIST_W = 31;
  localparam int VIDX_W = 6;
  localparam int VCNT_W = 7;
  localparam int LOAD_POS_BITS = 12;

  localparam logic [DIST_W-1:0] NO_PATH = 31'h7FFF_FFFF;
  localparam logic [DIST_W-1:0] SUM_CAP = 31'h7FFF_FFFE;

  localparam logic REG_VERTEX_COUNT  = 1'b0;
  localparam logic REG_SOURCE_VERTEX = 1'b1;

  localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;

  typedef struct packed {
    logic load_wr;
    logic start;
    logic cnt_clr;
    logic init_wr;
    logic scan_clr;
    logic sel_rd;
    logic commit;
    logic relax_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_done;
    logic src_ok;
    logic found;
    logic more_rounds;
  } sts_t;

endpackage

FILE: sv/dgsp_ram.sv
module dgsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/dgsp_ctrl.sv
module dgsp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          last_entry,
  input  logic          out_ready,
  input  dgsp_pkg::sts_t sts,
  output logic          in_ready,
  output logic          out_valid,
  output dgsp_pkg::cmd_t cmd
);

  import dgsp_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT,
    S_ROUND,
    S_SEL,
    S_DECIDE,
    S_RELAX,
    S_OUT_RD,
    S_OUT_CAP,
    S_OUT_HOLD
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_LOAD: begin
        if (in_valid && in_ready) begin
          cmd.load_wr = 1'b1;
          if (last_entry) begin
            cmd.start  = 1'b1;
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (!sts.cnt_done) begin
          cmd.init_wr = 1'b1;
        end else if (sts.src_ok) begin
          state_next = S_ROUND;
        end else begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_OUT_RD;
        end
      end
      S_ROUND: begin
        if (sts.more_rounds) begin
          cmd.scan_clr = 1'b1;
          state_next   = S_SEL;
        end else begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_OUT_RD;
        end
      end
      S_SEL: begin
        if (!sts.cnt_done) begin
          cmd.sel_rd = 1'b1;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.found) begin
          cmd.commit = 1'b1;
          state_next = S_RELAX;
        end else begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_OUT_RD;
        end
      end
      S_RELAX: begin
        if (!sts.cnt_done) begin
          cmd.relax_rd = 1'b1;
        end else begin
          state_next = S_ROUND;
        end
      end
      S_OUT_RD: begin
        state_next = S_OUT_CAP;
      end
      S_OUT_CAP: begin
        cmd.out_load = 1'b1;
        state_next   = S_OUT_HOLD;
      end
      S_OUT_HOLD: begin
        if (out_ready && out_valid) begin
          state_next = sts.cnt_done ? S_LOAD : S_OUT_RD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_ready  <= (state_next == S_LOAD);
      out_valid <= (state_next == S_OUT_HOLD);
    end
  end

endmodule

FILE: sv/dgsp_datapath.sv
module dgsp_datapath #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dgsp_pkg::cmd_t               cmd,
  output dgsp_pkg::sts_t               sts,
  input  logic [dgsp_pkg::EDGE_W-1:0]  edge_weight,
  input  logic                         last_entry,
  input  logic                         cfg_valid,
  input  logic                         cfg_index,
  input  logic [dgsp_pkg::VCNT_W-1:0]  cfg_data,
  output logic [dgsp_pkg::VIDX_W-1:0]  vertex_index,
  output logic [dgsp_pkg::DIST_W-1:0]  distance,
  output logic                         unreachable,
  output logic                         last_result
);

  import dgsp_pkg::*;

  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int CW    = $clog2(MAX_VERTICES + 1);
  localparam int SW    = (WEIGHT_BITS < EDGE_W) ? WEIGHT_BITS : EDGE_W;

  logic [VCNT_W-1:0]        vertex_count;
  logic [VIDX_W-1:0]        source_vertex;
  logic [LOAD_POS_BITS-1:0] load_pos;
  logic [AW-1:0]            load_addr;
  logic [CW-1:0]            n_reg;
  logic [CW-1:0]            n_next;
  logic [CW-1:0]            cnt;
  logic [CW-1:0]            rounds;
  logic [MAX_VERTICES-1:0]  visited;
  logic                     sel_pend;
  logic                     rlx_pend;
  logic [VW-1:0]            v_d;
  logic [DIST_W-1:0]        best;
  logic [VW-1:0]            best_v;
  logic                     found;
  logic [AW-1:0]            row_base;

  logic              w_we;
  logic [AW-1:0]     w_raddr;
  logic [SW-1:0]     w_rdata;
  logic              d_we;
  logic [VW-1:0]     d_waddr;
  logic [DIST_W-1:0] d_wdata;
  logic [DIST_W-1:0] d_rdata;

  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] sum_sat;
  logic              relax_wr;
  logic              init_is_src;
  logic              sel_better;

  always_comb begin
    if (vertex_count == '0) begin
      n_next = CW'(1);
    end else if (vertex_count > VCNT_W'(MAX_VERTICES)) begin
      n_next = CW'(MAX_VERTICES);
    end else begin
      n_next = CW'(vertex_count);
    end
  end

  assign sts.cnt_done    = (cnt == n_reg);
  assign sts.src_ok      = ({1'b0, source_vertex} < VCNT_W'(n_reg));
  assign sts.found       = found;
  assign sts.more_rounds = ((CW + 1)'(rounds) + (CW + 1)'(1)) < (CW + 1)'(n_reg);

  assign sum     = {1'b0, best} + (DIST_W + 1)'(w_rdata);
  assign sum_sat = (sum > {1'b0, SUM_CAP}) ? SUM_CAP : sum[DIST_W-1:0];

  assign relax_wr    = rlx_pend && !visited[v_d] && (w_rdata != '0) && (sum_sat < d_rdata);
  assign sel_better  = sel_pend && !visited[v_d] && (d_rdata < best);
  assign init_is_src = (VIDX_W'(cnt) == source_vertex);

  assign w_we    = cmd.load_wr;
  assign w_raddr = row_base + AW'(cnt);

  assign d_we    = cmd.init_wr || relax_wr;
  assign d_waddr = cmd.init_wr ? cnt[VW-1:0] : v_d;
  assign d_wdata = cmd.init_wr ? (init_is_src ? '0 : NO_PATH) : sum_sat;

  dgsp_ram #(
    .WIDTH(SW),
    .DEPTH(DEPTH)
  ) u_weight_ram (
    .clk  (clk),
    .we   (w_we),
    .waddr(load_addr),
    .wdata(edge_weight[SW-1:0]),
    .raddr(w_raddr),
    .rdata(w_rdata)
  );

  dgsp_ram #(
    .WIDTH(DIST_W),
    .DEPTH(MAX_VERTICES)
  ) u_dist_ram (
    .clk  (clk),
    .we   (d_we),
    .waddr(d_waddr),
    .wdata(d_wdata),
    .raddr(cnt[VW-1:0]),
    .rdata(d_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= VCNT_RESET;
      source_vertex <= '0;
      load_pos      <= '0;
      load_addr     <= '0;
      n_reg         <= CW'(MAX_VERTICES);
      cnt           <= '0;
      rounds        <= '0;
      visited       <= '0;
      sel_pend      <= 1'b0;
      rlx_pend      <= 1'b0;
      found         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_VERTEX_COUNT:  vertex_count  <= cfg_data;
          REG_SOURCE_VERTEX: source_vertex <= cfg_data[VIDX_W-1:0];
          default: begin
          end
        endcase
      end

      if (cmd.load_wr) begin
        if (last_entry) begin
          load_pos  <= '0;
          load_addr <= '0;
        end else begin
          load_pos <= load_pos + 1'b1;
          if (load_pos == '1 || load_addr == AW'(DEPTH - 1)) begin
            load_addr <= '0;
          end else begin
            load_addr <= load_addr + 1'b1;
          end
        end
      end

      if (cmd.start) begin
        n_reg   <= n_next;
        rounds  <= '0;
        visited <= '0;
      end

      if (cmd.start || cmd.cnt_clr || cmd.scan_clr || cmd.commit) begin
        cnt <= '0;
      end else if (cmd.init_wr || cmd.sel_rd || cmd.relax_rd || cmd.out_load) begin
        cnt <= cnt + 1'b1;
      end

      sel_pend <= cmd.sel_rd;
      rlx_pend <= cmd.relax_rd;

      if (cmd.scan_clr) begin
        found <= 1'b0;
      end else if (sel_better) begin
        found <= 1'b1;
      end

      if (cmd.commit) begin
        visited[best_v] <= 1'b1;
        rounds          <= rounds + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_d <= cnt[VW-1:0];
    if (cmd.scan_clr) begin
      best <= NO_PATH;
    end else if (sel_better) begin
      best   <= d_rdata;
      best_v <= v_d;
    end
    if (cmd.commit) begin
      row_base <= AW'(best_v * n_reg);
    end
    if (cmd.out_load) begin
      vertex_index <= VIDX_W'(cnt);
      distance     <= d_rdata;
      unreachable  <= (d_rdata == NO_PATH);
      last_result  <= ((cnt + 1'b1) == n_reg);
    end
  end

endmodule

FILE: sv/dense_graph_shortest_paths.sv
// Single-source shortest paths over a dense graph. The adjacency matrix is loaded in row-major
// order with a row stride of vertex_count, one edge weight per beat and one beat per cycle,
// where a weight of zero means no edge; the beat flagged last_entry starts the search from
// source_vertex, and the next matrix loads from entry zero again. No input is taken while a
// search runs or its results drain. A search first initialises the distance memory and then
// runs up to n-1 rounds, each a selection scan and a relaxation scan reading one distance
// memory word per cycle; it ends early once no reachable vertex is left. One result per
// vertex then follows in index order, each passing through a read, a capture and a hold
// state, where it waits while the sink holds off. Unreachable vertices report 2147483647 with
// the unreachable flag set, as do all vertices when the source lies at or above the vertex
// count. A vertex count of zero acts as one and values above MAX_VERTICES act as MAX_VERTICES.
// Configuration may be written only while the block is idle.
module dense_graph_shortest_paths #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dgsp_pkg::EDGE_W-1:0]  edge_weight,
  input  logic                         last_entry,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dgsp_pkg::VIDX_W-1:0]  vertex_index,
  output logic [dgsp_pkg::DIST_W-1:0]  distance,
  output logic                         unreachable,
  output logic                         last_result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [dgsp_pkg::VCNT_W-1:0]  cfg_data
);

  import dgsp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  dgsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_entry(last_entry),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  dgsp_datapath #(
    .MAX_VERTICES(MAX_VERTICES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .edge_weight (edge_weight),
    .last_entry  (last_entry),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .vertex_index(vertex_index),
    .distance    (distance),
    .unreachable (unreachable),
    .last_result (last_result)
  );

endmodule

FILE: sv/dgsp_checker.sv
`include "assert_macros.svh"

module dgsp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [dgsp_pkg::EDGE_W-1:0]  edge_weight,
  input logic                         last_entry,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [dgsp_pkg::VIDX_W-1:0]  vertex_index,
  input logic [dgsp_pkg::DIST_W-1:0]  distance,
  input logic                         unreachable,
  input logic                         last_result,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic                         cfg_index,
  input logic [dgsp_pkg::VCNT_W-1:0]  cfg_data
);

  import dgsp_pkg::*;

  `DGSP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(vertex_index) && $stable(distance) && $stable(last_result), "Result beat changed while stalled.")
  `DGSP_ASSERT_IMP(a_unreach_flag, out_valid, unreachable == (distance == NO_PATH), "Unreachable flag disagrees with distance.")
  `DGSP_ASSERT_IMP(a_no_overlap, out_valid, !in_ready, "Input taken while results are pending.")
  `DGSP_ASSERT_NXT(a_back_to_load, out_valid && out_ready && last_result, in_ready && !out_valid, "Block did not return to loading after the final result.")

endmodule

bind dense_graph_shortest_paths dgsp_checker u_dgsp_checker (.*);
